[sv/bool_expression_lexer_unit_defines.svh]
// assertion macros shared by the lexer rtl
`ifndef BOOL_EXPRESSION_LEXER_UNIT_DEFINES_SVH
`define BOOL_EXPRESSION_LEXER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BEL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bel assertion failed");

// next-cycle implication, disabled while in reset
`define BEL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bel assertion failed");

`endif

[sv/bel_pkg.sv]
package bel_pkg;

    localparam int KindWidth = 4;
    localparam int TokLenWidth = 16;

    typedef enum logic [KindWidth-1:0] {
        K_EOS     = 4'd0,
        K_SPACE   = 4'd1,
        K_NOTEQ   = 4'd2,
        K_AND     = 4'd3,
        K_OR      = 4'd4,
        K_LBR     = 4'd5,
        K_RBR     = 4'd6,
        K_LT      = 4'd7,
        K_LE      = 4'd8,
        K_EQ      = 4'd9,
        K_GT      = 4'd10,
        K_GE      = 4'd11,
        K_SYMBOL  = 4'd12,
        K_NUMBER  = 4'd13,
        K_UNKNOWN = 4'd14
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0,
        M_BANG = 4'd1,
        M_AMP  = 4'd2,
        M_LT   = 4'd3,
        M_EQ   = 4'd4,
        M_GT   = 4'd5,
        M_BAR  = 4'd6,
        M_A    = 4'd7,
        M_AN   = 4'd8,
        M_O    = 4'd9,
        M_SYM  = 4'd10,
        M_NUM  = 4'd11
    } t_mode;

    typedef struct packed {
        t_kind                   kind;
        logic [TokLenWidth-1:0]  length;
        logic                    last;
    } t_token;

    // up to two tokens per character: the closed held token, then its own
    typedef struct packed {
        logic   held_valid;
        logic   own_valid;
        t_token held;
        t_token own;
    } t_step;

endpackage

[sv/bel_char_if.sv]
interface bel_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface

[sv/bel_token_if.sv]
interface bel_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [15:0] tok_len;
    logic        last_of_run;

    modport source (output valid, output token_kind, output tok_len,
                    output last_of_run, input ready);
    modport sink (input valid, input token_kind, input tok_len,
                  input last_of_run, output ready);
endinterface

[sv/bool_expression_lexer_unit.sv]
// Boolean expression lexer. One character is taken per transaction on i_char,
// a zero character ends the string. Each character yields zero, one or two
// tokens on o_token: first the held token that it closes, then any token it
// completes by itself; last_of_run marks the final token of a character.
// Characters are registered, then lexed in one pass into a three-entry token
// queue that drives o_token. A character can be accepted every cycle while the
// queue keeps room for two tokens after this cycle's pop; the rate is limited
// by the one token per cycle output port and its ready, so characters that
// yield two tokens hold the input back.
// Symbol and number lengths saturate at 2^LEN_WIDTH - 1, reported at most 65535.
`include "bool_expression_lexer_unit_defines.svh"

module bool_expression_lexer_unit #(
    parameter int LEN_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bel_char_if.sink          i_char,
    bel_token_if.source       o_token
);

    localparam int QDepth = 3;

    logic                  r_in_valid;
    logic [7:0]            r_in_char;
    bel_pkg::t_mode        r_mode, n_mode;
    logic [LEN_WIDTH-1:0]  r_count, n_count;
    bel_pkg::t_token       r_q [QDepth];
    bel_pkg::t_token       n_q [QDepth];
    logic [1:0]            r_qcnt, n_qcnt;

    bel_pkg::t_mode        dec_mode;
    logic [LEN_WIDTH-1:0]  dec_count;
    bel_pkg::t_step        dec_step;

    logic                  pop, fire;
    logic [1:0]            keep, npush;
    bel_pkg::t_token       push0, push1;

    bel_decode #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_decode (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_char  (r_in_char),
        .o_mode  (dec_mode),
        .o_count (dec_count),
        .o_step  (dec_step)
    );

    assign pop  = o_token.valid && o_token.ready;
    assign keep = r_qcnt - {1'b0, pop};
    // room for two tokens after this cycle's pop
    assign fire = r_in_valid && (keep <= 2'd1);

    assign i_char.ready = !r_in_valid || fire;

    assign o_token.valid        = (r_qcnt != 2'd0);
    assign o_token.token_kind   = r_q[0].kind;
    assign o_token.tok_len      = r_q[0].length;
    assign o_token.last_of_run  = r_q[0].last;

    always_comb begin
        push0 = dec_step.held_valid ? dec_step.held : dec_step.own;
        push1 = dec_step.own;
        npush = fire ? (2'({1'b0, dec_step.held_valid}) + 2'({1'b0, dec_step.own_valid}))
                     : 2'd0;
        for (int i = 0; i < QDepth; i++) begin
            if (2'(i) < keep) begin
                n_q[i] = (pop && (i < QDepth - 1)) ? r_q[(i + 1) % QDepth] : r_q[i];
            end else if (2'(i) == keep) begin
                n_q[i] = push0;
            end else begin
                n_q[i] = push1;
            end
        end
        n_qcnt  = keep + npush;
        n_mode  = fire ? dec_mode : r_mode;
        n_count = fire ? dec_count : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= bel_pkg::M_IDLE;
            r_count    <= '0;
            r_qcnt     <= 2'd0;
        end else begin
            if (i_char.valid && i_char.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            r_mode  <= n_mode;
            r_count <= n_count;
            r_qcnt  <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_in_char <= i_char.char_in;
        end
        r_q <= n_q;
    end

    `BEL_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !fire, r_in_valid && $stable(r_in_char))
    `BEL_ASSERT_IMP(a_mode_count, i_clk, i_rst_n, 1'b1, (r_mode == bel_pkg::M_IDLE) == (r_count == '0))
    `BEL_ASSERT_IMP(a_pair_queued, i_clk, i_rst_n, o_token.valid && !o_token.last_of_run, r_qcnt >= 2'd2)

endmodule

[sv/bel_decode.sv]
module bel_decode #(
    parameter int LEN_WIDTH = 16
) (
    input  bel_pkg::t_mode         i_mode,
    input  logic [LEN_WIDTH-1:0]   i_count,
    input  logic [7:0]             i_char,
    output bel_pkg::t_mode         o_mode,
    output logic [LEN_WIDTH-1:0]   o_count,
    output bel_pkg::t_step         o_step
);

    localparam int SatWidth = (LEN_WIDTH > bel_pkg::TokLenWidth) ? LEN_WIDTH
                                                                 : bel_pkg::TokLenWidth;

    localparam logic [7:0] ChNul    = 8'h00;
    localparam logic [7:0] ChTab    = 8'h09;
    localparam logic [7:0] ChSpace  = 8'h20;
    localparam logic [7:0] ChBang   = 8'h21;
    localparam logic [7:0] ChAmp    = 8'h26;
    localparam logic [7:0] ChLbr    = 8'h28;
    localparam logic [7:0] ChRbr    = 8'h29;
    localparam logic [7:0] ChDash   = 8'h2D;
    localparam logic [7:0] ChLt     = 8'h3C;
    localparam logic [7:0] ChEq     = 8'h3D;
    localparam logic [7:0] ChGt     = 8'h3E;
    localparam logic [7:0] ChUnder  = 8'h5F;
    localparam logic [7:0] ChLowA   = 8'h61;
    localparam logic [7:0] ChLowD   = 8'h64;
    localparam logic [7:0] ChLowN   = 8'h6E;
    localparam logic [7:0] ChLowO   = 8'h6F;
    localparam logic [7:0] ChLowR   = 8'h72;
    localparam logic [7:0] ChBar    = 8'h7C;

    function automatic logic [bel_pkg::TokLenWidth-1:0] sat_len(
        input logic [LEN_WIDTH-1:0] cnt
    );
        logic [SatWidth-1:0] wide;
        wide = SatWidth'(cnt);
        if (wide > SatWidth'({bel_pkg::TokLenWidth{1'b1}}))
            return {bel_pkg::TokLenWidth{1'b1}};
        return wide[bel_pkg::TokLenWidth-1:0];
    endfunction

    function automatic logic [LEN_WIDTH-1:0] bump(input logic [LEN_WIDTH-1:0] cnt);
        return (cnt == {LEN_WIDTH{1'b1}}) ? cnt : cnt + LEN_WIDTH'(1);
    endfunction

    function automatic bel_pkg::t_token mk_tok(
        input bel_pkg::t_kind kind,
        input logic [bel_pkg::TokLenWidth-1:0] len
    );
        bel_pkg::t_token t;
        t.kind   = kind;
        t.length = len;
        t.last   = 1'b0;
        return t;
    endfunction

    logic is_alpha, is_digit, is_sym;
    assign is_alpha = ((i_char >= 8'h61) && (i_char <= 8'h7A))
                   || ((i_char >= 8'h41) && (i_char <= 8'h5A));
    assign is_digit = (i_char >= 8'h30) && (i_char <= 8'h39);
    assign is_sym   = is_alpha || is_digit || (i_char == ChUnder) || (i_char == ChDash);

    // lexing of the character as the first one of a new token
    logic            s_emit;
    bel_pkg::t_kind  s_kind;
    bel_pkg::t_mode  s_mode;

    always_comb begin
        s_emit = 1'b0;
        s_kind = bel_pkg::K_UNKNOWN;
        s_mode = bel_pkg::M_IDLE;
        case (i_char)
            ChNul: begin
                s_emit = 1'b1;
                s_kind = bel_pkg::K_EOS;
            end
            ChTab, ChSpace: begin
                s_emit = 1'b1;
                s_kind = bel_pkg::K_SPACE;
            end
            ChLbr: begin
                s_emit = 1'b1;
                s_kind = bel_pkg::K_LBR;
            end
            ChRbr: begin
                s_emit = 1'b1;
                s_kind = bel_pkg::K_RBR;
            end
            ChBang: s_mode = bel_pkg::M_BANG;
            ChAmp:  s_mode = bel_pkg::M_AMP;
            ChLt:   s_mode = bel_pkg::M_LT;
            ChEq:   s_mode = bel_pkg::M_EQ;
            ChGt:   s_mode = bel_pkg::M_GT;
            ChBar:  s_mode = bel_pkg::M_BAR;
            ChLowA: s_mode = bel_pkg::M_A;
            ChLowO: s_mode = bel_pkg::M_O;
            default: begin
                if (is_alpha) begin
                    s_mode = bel_pkg::M_SYM;
                end else if (is_digit) begin
                    s_mode = bel_pkg::M_NUM;
                end else begin
                    s_emit = 1'b1;
                    s_kind = bel_pkg::K_UNKNOWN;
                end
            end
        endcase
    end

    logic                 restart;
    logic [LEN_WIDTH-1:0] cnt_inc;
    assign cnt_inc = i_count + LEN_WIDTH'(1);

    always_comb begin
        o_step     = '0;
        o_mode     = bel_pkg::M_IDLE;
        o_count    = '0;
        restart    = 1'b0;
        o_step.held = mk_tok(bel_pkg::K_UNKNOWN, 16'd1);
        unique case (i_mode)
            bel_pkg::M_BANG: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChEq) begin
                    o_step.held = mk_tok(bel_pkg::K_NOTEQ, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_UNKNOWN, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_AMP: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChAmp) begin
                    o_step.held = mk_tok(bel_pkg::K_AND, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_AND, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_LT: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChGt) begin
                    o_step.held = mk_tok(bel_pkg::K_NOTEQ, 16'd2);
                end else if (i_char == ChEq) begin
                    o_step.held = mk_tok(bel_pkg::K_LE, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_LT, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_EQ: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChEq) begin
                    o_step.held = mk_tok(bel_pkg::K_EQ, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_EQ, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_GT: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChEq) begin
                    o_step.held = mk_tok(bel_pkg::K_GE, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_GT, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_BAR: begin
                o_step.held_valid = 1'b1;
                if (i_char == ChBar) begin
                    o_step.held = mk_tok(bel_pkg::K_OR, 16'd2);
                end else begin
                    o_step.held = mk_tok(bel_pkg::K_OR, 16'd1);
                    restart = 1'b1;
                end
            end
            bel_pkg::M_A, bel_pkg::M_AN, bel_pkg::M_O: begin
                // keyword prefix: extend, fall back to a symbol, or close
                if ((i_mode == bel_pkg::M_A) && (i_char == ChLowN)) begin
                    o_mode  = bel_pkg::M_AN;
                    o_count = cnt_inc;
                end else if ((i_mode == bel_pkg::M_AN) && (i_char == ChLowD)) begin
                    o_step.held_valid = 1'b1;
                    o_step.held = mk_tok(bel_pkg::K_AND, sat_len(cnt_inc));
                end else if ((i_mode == bel_pkg::M_O) && (i_char == ChLowR)) begin
                    o_step.held_valid = 1'b1;
                    o_step.held = mk_tok(bel_pkg::K_OR, sat_len(cnt_inc));
                end else if (is_sym) begin
                    o_mode  = bel_pkg::M_SYM;
                    o_count = bump(i_count);
                end else begin
                    o_step.held_valid = 1'b1;
                    o_step.held = mk_tok(bel_pkg::K_SYMBOL, sat_len(i_count));
                    restart = 1'b1;
                end
            end
            bel_pkg::M_SYM: begin
                if (is_sym) begin
                    o_mode  = bel_pkg::M_SYM;
                    o_count = bump(i_count);
                end else begin
                    o_step.held_valid = 1'b1;
                    o_step.held = mk_tok(bel_pkg::K_SYMBOL, sat_len(i_count));
                    restart = 1'b1;
                end
            end
            bel_pkg::M_NUM: begin
                if (is_digit) begin
                    o_mode  = bel_pkg::M_NUM;
                    o_count = bump(i_count);
                end else begin
                    o_step.held_valid = 1'b1;
                    o_step.held = mk_tok(bel_pkg::K_NUMBER, sat_len(i_count));
                    restart = 1'b1;
                end
            end
            default: restart = 1'b1;
        endcase

        if (restart) begin
            o_mode           = s_mode;
            o_count          = (s_mode == bel_pkg::M_IDLE) ? '0 : LEN_WIDTH'(1);
            o_step.own_valid = s_emit;
            o_step.own       = mk_tok(s_kind, 16'd1);
        end else begin
            o_step.own = mk_tok(bel_pkg::K_UNKNOWN, 16'd1);
        end
        o_step.own.last  = 1'b1;
        o_step.held.last = !o_step.own_valid;
    end

endmodule
